// ===== hdl/fmnl_pkg.sv =====
// -----------------------------------------------------------------------------
// fmnl_pkg
// Shared types and constants of the nearest-neighbor field map lookup.
// -----------------------------------------------------------------------------
package fmnl_pkg;

   // grid dimensions, entries per axis
   localparam int GRID_X = 32;
   localparam int GRID_Y = 32;
   localparam int GRID_Z = 64;

   // largest grid size is 64, so an index fits well within 10 bits
   localparam int IDX_W  = 10;
   localparam int SIZE_W = IDX_W + 1;

   localparam int TABLE_DEPTH = 65536;
   localparam int ADDR_W      = $clog2(TABLE_DEPTH);
   localparam int ENTRY_W     = 48;

   // address strides of the flat table, j outermost, k innermost
   localparam int STRIDE_J = GRID_X * GRID_Z;
   localparam int STRIDE_I = GRID_Z;

   localparam int POS_W  = 24;
   localparam int LIM_W  = 23;
   localparam int INV_W  = 20;
   localparam int CSR_W  = 60;
   localparam int CIDX_W = 3;

   typedef enum logic {
      OP_LOOKUP = 1'b0,
      OP_WRITE  = 1'b1
   } op_type;

   typedef enum logic [CIDX_W-1:0] {
      CSR_X_LOW     = 3'd0,
      CSR_Y_LOW     = 3'd1,
      CSR_Z_LOW     = 3'd2,
      CSR_X_LIMIT   = 3'd3,
      CSR_Y_LIMIT   = 3'd4,
      CSR_Z_LIMIT   = 3'd5,
      CSR_INV_STEPS = 3'd6
   } csr_index_type;

   // load enables of the per-axis pipeline stages
   typedef struct packed {
      logic s2;
      logic s3;
   } stage_en_type;

endpackage

// ===== hdl/fmnl_ifs.sv =====
// -----------------------------------------------------------------------------
// fmnl request and response channels
// Valid/ready channels carrying lookup/write beats and field results.
// -----------------------------------------------------------------------------
interface fmnl_req_if ();
   logic               valid;
   logic               ready;
   logic               operation;
   logic signed [23:0] pos_x;
   logic signed [23:0] pos_y;
   logic signed [23:0] pos_z;
   logic        [15:0] entry_index;
   logic signed [15:0] entry_bx;
   logic signed [15:0] entry_by;
   logic signed [15:0] entry_bz;

   modport source (output valid, operation, pos_x, pos_y, pos_z, entry_index,
                   entry_bx, entry_by, entry_bz, input ready);
   modport sink   (input valid, operation, pos_x, pos_y, pos_z, entry_index,
                   entry_bx, entry_by, entry_bz, output ready);
endinterface

interface fmnl_rsp_if ();
   logic               valid;
   logic               ready;
   logic signed [16:0] field_x;
   logic signed [15:0] field_y;
   logic signed [16:0] field_z;
   logic               inside_res;

   modport source (output valid, field_x, field_y, field_z, inside_res,
                   input ready);
   modport sink   (input valid, field_x, field_y, field_z, inside_res,
                   output ready);
endinterface

// ===== hdl/field_map_nearest_lookup.sv =====
// -----------------------------------------------------------------------------
// field_map_nearest_lookup
// Nearest-neighbor lookup in a 3-D magnetic field map held in a table memory.
// -----------------------------------------------------------------------------
// The block accepts one beat per clock on req_bus while rsp_bus is not stalled:
// a write beat stores one 48-bit entry (Bx, By, Bz) at entry_index, a lookup
// beat returns one result beat on rsp_bus and a write beat returns none. Throughput
// is one beat per cycle when rsp_bus is not stalled, set by the five register
// stages (input, offset, product, table read, result) and the single table
// port shared in order by reads and writes. Each stage holds its beat only
// when the stage after it is full and stalled, so input beats keep flowing
// into empty stages while a result waits. The csr port loads the grid
// origins, the absolute limits and the packed Q4.16 inverse steps; write it
// only while no beat is in flight. The table needs no clear after reset, but
// an entry must be written before a lookup lands on it.
// -----------------------------------------------------------------------------
module field_map_nearest_lookup import fmnl_pkg::*; (
   input  logic              clock,
   input  logic              reset,
   fmnl_req_if.sink          req_bus,
   fmnl_rsp_if.source        rsp_bus,
   input  logic              csr_wr_en,
   input  logic [CIDX_W-1:0] csr_index,
   input  logic [CSR_W-1:0]  csr_wr_data
);

   // configuration registers
   logic signed [POS_W-1:0] x_low_ff, y_low_ff, z_low_ff;
   logic        [LIM_W-1:0] x_limit_ff, y_limit_ff, z_limit_ff;
   logic        [CSR_W-1:0] inv_steps_ff;

   // stage 1: input register
   logic                    s1_v_ff;
   logic                    s1_op_ff;
   logic signed [POS_W-1:0] s1_px_ff, s1_py_ff, s1_pz_ff;
   logic [ADDR_W-1:0]       s1_index_ff;
   logic [ENTRY_W-1:0]      s1_data_ff;

   // stages 2 and 3: beat control and write payload alongside the axis units
   logic                    s2_v_ff, s2_op_ff, s2_negx_ff, s2_negz_ff;
   logic [ADDR_W-1:0]       s2_index_ff;
   logic [ENTRY_W-1:0]      s2_data_ff;
   logic                    s3_v_ff, s3_op_ff, s3_negx_ff, s3_negz_ff;
   logic [ADDR_W-1:0]       s3_index_ff;
   logic [ENTRY_W-1:0]      s3_data_ff;

   // stage 4: table read data
   logic                    s4_v_ff, s4_inside_ff, s4_negx_ff, s4_negz_ff;
   logic [ENTRY_W-1:0]      rd_data_ff;

   // result register
   logic                    rsp_v_ff;
   logic signed [16:0]      rsp_fx_ff, rsp_fz_ff;
   logic signed [15:0]      rsp_fy_ff;
   logic                    rsp_inside_ff;

   logic [ENTRY_W-1:0]      field_table_ff [TABLE_DEPTH];

   logic rsp_free, s4_free, s3_free, s2_free, s1_free;
   logic s3_adv;
   stage_en_type axis_en;

   logic             ok_x, ok_y, ok_z, in_grid;
   logic [IDX_W-1:0] idx_i, idx_j, idx_k;
   logic [ADDR_W-1:0] rd_addr;

   logic signed [16:0] bx_ext, bz_ext, fx_in, fz_in;
   logic signed [15:0] fy_in;

   // -------------------------------------------------------------------------
   // configuration writes, unknown indexes fall through
   // -------------------------------------------------------------------------
   always_ff @(posedge clock) begin
      if (reset) begin
         x_low_ff     <= '0;
         y_low_ff     <= '0;
         z_low_ff     <= '0;
         x_limit_ff   <= '0;
         y_limit_ff   <= '0;
         z_limit_ff   <= '0;
         inv_steps_ff <= '0;
      end else if (csr_wr_en) begin
         case (csr_index_type'(csr_index))
            CSR_X_LOW:     x_low_ff     <= csr_wr_data[POS_W-1:0];
            CSR_Y_LOW:     y_low_ff     <= csr_wr_data[POS_W-1:0];
            CSR_Z_LOW:     z_low_ff     <= csr_wr_data[POS_W-1:0];
            CSR_X_LIMIT:   x_limit_ff   <= csr_wr_data[LIM_W-1:0];
            CSR_Y_LIMIT:   y_limit_ff   <= csr_wr_data[LIM_W-1:0];
            CSR_Z_LIMIT:   z_limit_ff   <= csr_wr_data[LIM_W-1:0];
            CSR_INV_STEPS: inv_steps_ff <= csr_wr_data;
            default: ;
         endcase
      end
   end

   // -------------------------------------------------------------------------
   // stage flow: a stage loads when it is empty or its beat moves on
   // -------------------------------------------------------------------------
   assign rsp_free = !rsp_v_ff || rsp_bus.ready;
   assign s4_free  = !s4_v_ff  || rsp_free;
   assign s3_free  = !s3_v_ff  || s4_free;
   assign s2_free  = !s2_v_ff  || s3_free;
   assign s1_free  = !s1_v_ff  || s2_free;
   assign s3_adv   = s3_v_ff && s4_free;

   assign req_bus.ready = s1_free;
   assign axis_en.s2    = s2_free;
   assign axis_en.s3    = s3_free;

   always_ff @(posedge clock) begin
      if (reset) begin
         s1_v_ff  <= 1'b0;
         s2_v_ff  <= 1'b0;
         s3_v_ff  <= 1'b0;
         s4_v_ff  <= 1'b0;
         rsp_v_ff <= 1'b0;
      end else begin
         if (s1_free)  s1_v_ff  <= req_bus.valid;
         if (s2_free)  s2_v_ff  <= s1_v_ff;
         if (s3_free)  s3_v_ff  <= s2_v_ff;
         // write beats end at the table and produce no result
         if (s4_free)  s4_v_ff  <= s3_v_ff && (s3_op_ff == OP_LOOKUP);
         if (rsp_free) rsp_v_ff <= s4_v_ff;
      end
   end

   // stage payloads
   always_ff @(posedge clock) begin
      if (s1_free) begin
         s1_op_ff    <= req_bus.operation;
         s1_px_ff    <= req_bus.pos_x;
         s1_py_ff    <= req_bus.pos_y;
         s1_pz_ff    <= req_bus.pos_z;
         s1_index_ff <= req_bus.entry_index;
         s1_data_ff  <= {req_bus.entry_bz, req_bus.entry_by, req_bus.entry_bx};
      end
      if (s2_free) begin
         s2_op_ff    <= s1_op_ff;
         // Bx flips in quadrants 2 and 4, Bz in quadrants 3 and 4
         s2_negx_ff  <= s1_px_ff[POS_W-1] ^ s1_py_ff[POS_W-1];
         s2_negz_ff  <= s1_py_ff[POS_W-1];
         s2_index_ff <= s1_index_ff;
         s2_data_ff  <= s1_data_ff;
      end
      if (s3_free) begin
         s3_op_ff    <= s2_op_ff;
         s3_negx_ff  <= s2_negx_ff;
         s3_negz_ff  <= s2_negz_ff;
         s3_index_ff <= s2_index_ff;
         s3_data_ff  <= s2_data_ff;
      end
      if (s4_free) begin
         s4_inside_ff <= in_grid;
         s4_negx_ff   <= s3_negx_ff;
         s4_negz_ff   <= s3_negz_ff;
      end
      if (rsp_free) begin
         rsp_fx_ff     <= fx_in;
         rsp_fy_ff     <= fy_in;
         rsp_fz_ff     <= fz_in;
         rsp_inside_ff <= s4_inside_ff;
      end
   end

   // -------------------------------------------------------------------------
   // per-axis index units; x and y are folded, z keeps its sign
   // -------------------------------------------------------------------------
   fmnl_axis u_axis_x (
      .clock (clock),
      .en    (axis_en),
      .pos   (s1_px_ff),
      .fold  (1'b1),
      .low   (x_low_ff),
      .limit (x_limit_ff),
      .inv   (inv_steps_ff[INV_W-1:0]),
      .size  (SIZE_W'(GRID_X)),
      .ok    (ok_x),
      .idx   (idx_i)
   );

   fmnl_axis u_axis_y (
      .clock (clock),
      .en    (axis_en),
      .pos   (s1_py_ff),
      .fold  (1'b1),
      .low   (y_low_ff),
      .limit (y_limit_ff),
      .inv   (inv_steps_ff[2*INV_W-1:INV_W]),
      .size  (SIZE_W'(GRID_Y)),
      .ok    (ok_y),
      .idx   (idx_j)
   );

   fmnl_axis u_axis_z (
      .clock (clock),
      .en    (axis_en),
      .pos   (s1_pz_ff),
      .fold  (1'b0),
      .low   (z_low_ff),
      .limit (z_limit_ff),
      .inv   (inv_steps_ff[3*INV_W-1:2*INV_W]),
      .size  (SIZE_W'(GRID_Z)),
      .ok    (ok_z),
      .idx   (idx_k)
   );

   assign in_grid = ok_x && ok_y && ok_z;

   // flat address, wraps to the table width
   assign rd_addr = ADDR_W'(32'(idx_j) * STRIDE_J + 32'(idx_i) * STRIDE_I + 32'(idx_k));

   // -------------------------------------------------------------------------
   // field table: one port, reads and writes taken in beat order at stage 3
   // -------------------------------------------------------------------------
   always_ff @(posedge clock) begin
      if (s3_adv && (s3_op_ff == OP_WRITE)) begin
         field_table_ff[s3_index_ff] <= s3_data_ff;
      end
      if (s4_free) begin
         rd_data_ff <= field_table_ff[rd_addr];
      end
   end

   // -------------------------------------------------------------------------
   // symmetry signs and outside masking
   // -------------------------------------------------------------------------
   assign bx_ext = {rd_data_ff[15], rd_data_ff[15:0]};
   assign bz_ext = {rd_data_ff[47], rd_data_ff[47:32]};

   always_comb begin
      fx_in = '0;
      fy_in = '0;
      fz_in = '0;
      if (s4_inside_ff) begin
         fx_in = s4_negx_ff ? (17'sd0 - bx_ext) : bx_ext;
         fy_in = rd_data_ff[31:16];
         fz_in = s4_negz_ff ? (17'sd0 - bz_ext) : bz_ext;
      end
   end

   assign rsp_bus.valid      = rsp_v_ff;
   assign rsp_bus.field_x    = rsp_fx_ff;
   assign rsp_bus.field_y    = rsp_fy_ff;
   assign rsp_bus.field_z    = rsp_fz_ff;
   assign rsp_bus.inside_res = rsp_inside_ff;

   // -------------------------------------------------------------------------
   // assertions
   // -------------------------------------------------------------------------
   a_write_no_result: assert property (@(posedge clock) disable iff (reset)
      (s3_adv && (s3_op_ff == OP_WRITE)) |=> !s4_v_ff)
      else $error("write beat produced a result");

   a_outside_zero: assert property (@(posedge clock) disable iff (reset)
      (rsp_bus.valid && !rsp_bus.inside_res) |->
         (rsp_bus.field_x == 0 && rsp_bus.field_y == 0 && rsp_bus.field_z == 0))
      else $error("outside result carries a nonzero field");

   a_read_hold: assert property (@(posedge clock) disable iff (reset)
      (s4_v_ff && !rsp_free) |=> $stable(rd_data_ff))
      else $error("table read data changed while stalled");

   a_full_backpressure: assert property (@(posedge clock) disable iff (reset)
      (s1_v_ff && !s2_free) |-> !req_bus.ready)
      else $error("input accepted into a full stalled pipeline");

endmodule

// ===== hdl/fmnl_axis.sv =====
// -----------------------------------------------------------------------------
// fmnl_axis
// One axis of the grid index: limit check, offset, scale and round.
// -----------------------------------------------------------------------------
module fmnl_axis import fmnl_pkg::*; (
   input  logic                     clock,
   input  stage_en_type             en,
   input  logic signed [POS_W-1:0]  pos,
   input  logic                     fold,
   input  logic signed [POS_W-1:0]  low,
   input  logic        [LIM_W-1:0]  limit,
   input  logic        [INV_W-1:0]  inv,
   input  logic        [SIZE_W-1:0] size,
   output logic                     ok,
   output logic        [IDX_W-1:0]  idx
);

   localparam int D_W    = POS_W + 2;
   localparam int MAG_W  = POS_W + 1;
   localparam int PROD_W = MAG_W + INV_W;
   localparam int R_W    = PROD_W - 16;

   logic        [POS_W-1:0]  pos_abs;
   logic                     lim_ok;
   logic signed [D_W-1:0]    a_ext;
   logic signed [D_W-1:0]    low_ext;
   logic signed [D_W-1:0]    d;
   logic        [MAG_W-1:0]  mag_in;

   logic        [MAG_W-1:0]  mag_ff;
   logic                     neg_s2_ff;
   logic                     lim_s2_ff;

   logic        [PROD_W-1:0] prod_in;
   logic        [PROD_W-1:0] prod_ff;
   logic                     neg_s3_ff;
   logic                     lim_s3_ff;

   logic        [PROD_W-1:0] rnd;
   logic        [R_W-1:0]    r;

   // magnitude; the most negative position maps to 2^23, which still fits
   assign pos_abs = pos[POS_W-1] ? (POS_W'(0) - POS_W'(pos)) : POS_W'(pos);
   assign lim_ok  = pos_abs <= {1'b0, limit};

   assign a_ext   = fold ? D_W'({2'b00, pos_abs}) : {{2{pos[POS_W-1]}}, pos};
   assign low_ext = {{2{low[POS_W-1]}}, low};
   assign d       = a_ext - low_ext;
   assign mag_in  = MAG_W'(d[D_W-1] ? (D_W'(0) - d) : d);

   always_ff @(posedge clock) begin
      if (en.s2) begin
         mag_ff    <= mag_in;
         neg_s2_ff <= d[D_W-1];
         lim_s2_ff <= lim_ok;
      end
   end

   assign prod_in = PROD_W'(mag_ff) * PROD_W'(inv);

   always_ff @(posedge clock) begin
      if (en.s3) begin
         prod_ff   <= prod_in;
         neg_s3_ff <= neg_s2_ff;
         lim_s3_ff <= lim_s2_ff;
      end
   end

   // round half away from zero on the magnitude, 16 fraction bits
   assign rnd = prod_ff + PROD_W'(32768);
   assign r   = rnd[PROD_W-1:16];

   assign ok  = lim_s3_ff && !(neg_s3_ff && (r != '0)) && (r < R_W'(size));
   assign idx = r[IDX_W-1:0];

endmodule
